[rtl/tx_retry_queue_unit_defines.svh]
// ----------------------------------------------------------------------------
// tx_retry_queue_unit_defines.svh
// Assertion macros shared by the transmit retry queue RTL.
// ----------------------------------------------------------------------------
`ifndef TX_RETRY_QUEUE_UNIT_DEFINES_SVH
`define TX_RETRY_QUEUE_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TRQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define TRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/trq_pkg.sv]
// ----------------------------------------------------------------------------
// trq_pkg
// Types, codes and reset values of the transmit retry queue.
// ----------------------------------------------------------------------------
package trq_pkg;

  // Command codes of the input transaction
  localparam logic [1:0] CMD_ENQ     = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_OUTCOME = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ENQ    = 2'd0;
  localparam logic [1:0] KIND_IDLE   = 2'd1;
  localparam logic [1:0] KIND_TX     = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // Outcome reports
  localparam logic [1:0] REP_SENT  = 2'd0;
  localparam logic [1:0] REP_RETRY = 2'd1;
  localparam logic [1:0] REP_DROP  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIO_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_SERVER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_GAP    = 3'd5;

  // Reset values of the configuration registers
  localparam logic [3:0]  RST_QUEUE_LIMIT = 4'd10;
  localparam logic [3:0]  RST_MAX_RETRIES = 4'd10;
  localparam logic [15:0] RST_RETRY_DELAY = 16'd1000;
  localparam logic [15:0] RST_SEND_GAP    = 16'd100;

  // Tag in the top nibble of every packed message
  localparam logic [3:0] MSG_TAG = 4'hD;

  // Highest retry count that can be reported
  localparam logic [3:0] RETRY_SAT = 4'hF;

  localparam int DEF_QUEUE_DEPTH = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  dev_cmd;
    logic [7:0]  dev_id;
    logic [15:0] payload;
    logic [7:0]  dest_node;
    logic        write_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [31:0] message;
    logic [7:0]  out_node;
    logic [1:0]  report;
    logic [3:0]  retry_count;
    logic        link_up;
  } result_t;

  typedef struct packed {
    logic [31:0] message;
    logic [7:0]  node;
    logic [3:0]  retries;
    logic [31:0] retry_time;
  } qentry_t;

  typedef struct packed {
    logic [31:0] message;
    logic [7:0]  node;
    logic [3:0]  retries;
  } flight_t;

  typedef struct packed {
    logic        radio_en;
    logic        is_server;
    logic [3:0]  queue_limit;
    logic [3:0]  max_retries;
    logic [15:0] retry_delay;
    logic [15:0] send_gap;
  } cfg_t;

endpackage

[rtl/trq_stream_if.sv]
// ----------------------------------------------------------------------------
// trq_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface trq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/trq_queue_mem.sv]
// ----------------------------------------------------------------------------
// trq_queue_mem
// Circular queue storage: one write port, one registered read port with
// write-to-read forwarding so the head entry is always ready.
// ----------------------------------------------------------------------------
module trq_queue_mem #(
  parameter  int DEPTH = trq_pkg::DEF_QUEUE_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  trq_pkg::qentry_t  wr_data,
  input  logic [AW-1:0]     rd_addr,
  output trq_pkg::qentry_t  rd_data
);

  trq_pkg::qentry_t mem [DEPTH];
  trq_pkg::qentry_t rd_data_r;

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the next head entry; forward a write to the same address
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/trq_ctrl.sv]
// ----------------------------------------------------------------------------
// trq_ctrl
// Queue pointers, in-flight packet, millisecond clock, link flag and
// configuration; computes the result of one command in a single pass.
// ----------------------------------------------------------------------------
`include "tx_retry_queue_unit_defines.svh"

module trq_ctrl #(
  parameter  int QUEUE_DEPTH = trq_pkg::DEF_QUEUE_DEPTH,
  localparam int AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [trq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             fire,
  input  trq_pkg::item_t                   item,
  input  trq_pkg::qentry_t                 head_entry,
  output trq_pkg::result_t                 result,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output trq_pkg::qentry_t                 wr_data,
  output logic [AW-1:0]                    rd_addr
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  trq_pkg::cfg_t    cfg_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_flight_r, in_flight_nxt;
  trq_pkg::flight_t flight_r, flight_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [31:0]      next_send_r, next_send_nxt;
  logic             server_up_r, server_up_nxt;

  logic [31:0]      msg;
  logic             q_empty;
  logic             q_full;
  logic             over_limit;
  logic             enq_ok;
  logic [31:0]      now_inc;
  logic             tx_ok;
  logic [3:0]       retry_inc;
  logic             requeue_ok;
  logic [AW-1:0]    head_inc;
  logic [AW-1:0]    tail_inc;

  // Decode queue status and the conditions of each command
  assign msg        = {trq_pkg::MSG_TAG, item.dev_cmd, item.dev_id, item.payload};
  assign q_empty    = (count_r == '0);
  assign q_full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign over_limit = (CMP_W'(count_r) > CMP_W'(cfg_r.queue_limit));
  assign enq_ok     = cfg_r.radio_en && (server_up_r || q_empty) && !over_limit && !q_full;
  assign now_inc    = now_r + 32'd1;
  assign tx_ok      = cfg_r.radio_en && !in_flight_r && (next_send_r <= now_inc) && !q_empty
                      && ((head_entry.retries == '0) || (head_entry.retry_time <= now_inc));
  assign retry_inc  = (flight_r.retries == trq_pkg::RETRY_SAT) ? trq_pkg::RETRY_SAT
                                                                : flight_r.retries + 4'd1;
  assign requeue_ok = (flight_r.retries < cfg_r.max_retries) && !q_full;
  assign head_inc   = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_inc   = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);

  // Work out next state, queue write and result of the current command
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    in_flight_nxt = in_flight_r;
    flight_nxt    = flight_r;
    now_nxt       = now_r;
    next_send_nxt = next_send_r;
    server_up_nxt = server_up_r;
    wr_en         = 1'b0;
    wr_data       = '0;
    result        = '0;
    result.kind   = trq_pkg::KIND_IDLE;

    if (fire) begin
      unique case (item.cmd)
        trq_pkg::CMD_ENQ: begin
          result.kind     = trq_pkg::KIND_ENQ;
          result.accepted = enq_ok;
          result.message  = msg;
          result.out_node = item.dest_node;
          if (enq_ok) begin
            wr_en     = 1'b1;
            wr_data   = '{message: msg, node: item.dest_node, retries: 4'd0,
                          retry_time: 32'd0};
            tail_nxt  = tail_inc;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        trq_pkg::CMD_TICK: begin
          now_nxt = now_inc;
          if (tx_ok) begin
            flight_nxt         = '{message: head_entry.message, node: head_entry.node,
                                   retries: head_entry.retries};
            head_nxt           = head_inc;
            count_nxt          = count_r - CNT_W'(1);
            in_flight_nxt      = 1'b1;
            result.kind        = trq_pkg::KIND_TX;
            result.message     = head_entry.message;
            result.out_node    = head_entry.node;
            result.retry_count = head_entry.retries;
          end
        end
        trq_pkg::CMD_OUTCOME: begin
          if (in_flight_r) begin
            in_flight_nxt   = 1'b0;
            result.kind     = trq_pkg::KIND_REPORT;
            result.message  = flight_r.message;
            result.out_node = flight_r.node;
            if (item.write_ok) begin
              result.report      = trq_pkg::REP_SENT;
              result.retry_count = flight_r.retries;
              if (!cfg_r.is_server) begin
                server_up_nxt = 1'b1;
              end
            end else begin
              result.retry_count = retry_inc;
              if (requeue_ok) begin
                result.report = trq_pkg::REP_RETRY;
                wr_en         = 1'b1;
                wr_data       = '{message: flight_r.message, node: flight_r.node,
                                  retries: retry_inc,
                                  retry_time: now_r + {16'd0, cfg_r.retry_delay}};
                tail_nxt      = tail_inc;
                count_nxt     = count_r + CNT_W'(1);
              end else begin
                result.report = trq_pkg::REP_DROP;
                if (!cfg_r.is_server) begin
                  server_up_nxt = 1'b0;
                end
              end
            end
            next_send_nxt = now_r + {16'd0, cfg_r.send_gap};
          end
        end
        default: begin
          // unused command: nothing to do
        end
      endcase
    end

    result.link_up = server_up_nxt;
  end

  assign wr_addr = tail_r;
  assign rd_addr = head_nxt;

  // Hold queue, flight and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      in_flight_r <= 1'b0;
      flight_r    <= '0;
      now_r       <= '0;
      next_send_r <= '0;
      server_up_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      in_flight_r <= in_flight_nxt;
      flight_r    <= flight_nxt;
      now_r       <= now_nxt;
      next_send_r <= next_send_nxt;
      server_up_r <= server_up_nxt;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radio_en    <= 1'b0;
      cfg_r.is_server   <= 1'b0;
      cfg_r.queue_limit <= trq_pkg::RST_QUEUE_LIMIT;
      cfg_r.max_retries <= trq_pkg::RST_MAX_RETRIES;
      cfg_r.retry_delay <= trq_pkg::RST_RETRY_DELAY;
      cfg_r.send_gap    <= trq_pkg::RST_SEND_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trq_pkg::CFG_RADIO_EN:    cfg_r.radio_en    <= cfg_data[0];
        trq_pkg::CFG_IS_SERVER:   cfg_r.is_server   <= cfg_data[0];
        trq_pkg::CFG_QUEUE_LIMIT: cfg_r.queue_limit <= cfg_data[3:0];
        trq_pkg::CFG_MAX_RETRIES: cfg_r.max_retries <= cfg_data[3:0];
        trq_pkg::CFG_RETRY_DELAY: cfg_r.retry_delay <= cfg_data;
        trq_pkg::CFG_SEND_GAP:    cfg_r.send_gap    <= cfg_data;
        default: begin
          // index beyond the register list: ignore
        end
      endcase
    end
  end

  // Queue occupancy agrees with the pointers
  `TRQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `TRQ_ASSERT_SAME(a_ptr_match, clk, rst_n, (count_r == '0) || q_full, head_r == tail_r)
  // A transmit request leaves a packet in flight
  `TRQ_ASSERT_NEXT(a_tx_flight, clk, rst_n, fire && (result.kind == trq_pkg::KIND_TX),
                   in_flight_r)
  // An outcome report needs a packet in flight and clears it
  `TRQ_ASSERT_NEXT(a_report_clr, clk, rst_n, fire && (result.kind == trq_pkg::KIND_REPORT),
                   !in_flight_r)

endmodule

[rtl/tx_retry_queue_unit.sv]
// ----------------------------------------------------------------------------
// tx_retry_queue_unit
// Transmit queue with retries for a packet radio link.
//
//   channel   dir  payload             transfer
//   in_chan   in   trq_pkg::item_t     valid & ready
//   out_chan  out  trq_pkg::result_t   valid & ready
//   cfg_*     in   index + 16b data    cfg_we, no read-back
//
// One command per cycle while the result channel does not stall; a taken
// transaction passes the input register, then the result register.
// The single-pass control logic plus one queue read port set this rate:
// the head entry is prefetched into a register every cycle.
// rst_n is synchronous; the queue storage is not cleared and needs no sweep.
// A stalled result holds the pipe; the input register still takes a
// transaction while the result register drains.
// ----------------------------------------------------------------------------
module tx_retry_queue_unit #(
  parameter int QUEUE_DEPTH = trq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  trq_stream_if.sink                      in_chan,
  trq_stream_if.source                    out_chan,
  input  logic                            cfg_we,
  input  logic [trq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic             in_valid_r;
  trq_pkg::item_t   in_item_r;
  logic             out_valid_r;
  trq_pkg::result_t out_res_r;
  logic             fire;
  trq_pkg::result_t result;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  trq_pkg::qentry_t wr_data;
  logic [AW-1:0]    rd_addr;
  trq_pkg::qentry_t head_entry;

  // Advance when the result register is free or being drained
  assign fire          = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || fire;

  // Hold valid flags of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture transaction and result payloads
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r <= in_chan.data;
    end
    if (fire) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_res_r;

  trq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .item       (in_item_r),
    .head_entry (head_entry),
    .result     (result),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr)
  );

  trq_queue_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (head_entry)
  );

endmodule

[tb/tb_tx_retry_queue_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tx_retry_queue_unit
// Self-checking bench for the transmit retry queue. A clocked driver feeds
// enqueue, tick and outcome commands from a backlog. A clocked monitor runs
// each taken command through a behavioral copy of the queue and checks every
// result against it. Both sides idle and stall at random. Several register
// settings are used, extremes included.
// ----------------------------------------------------------------------------
module tb_tx_retry_queue_unit;
  import trq_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  localparam int STALL_LIMIT = 3000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  trq_stream_if #(.payload_t(item_t)) in_chan ();
  trq_stream_if #(.payload_t(result_t)) out_chan ();

  tx_retry_queue_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the queue state and registers
  qentry_t ring [QDEPTH];
  int unsigned head_q, tail_q, count_q;
  bit flying;
  flight_t flight;
  logic [31:0] now_ms, next_send;
  bit link_up;
  cfg_t radio_cfg;

  item_t cmd_backlog [$];
  result_t result_queue [$];
  int cmds_issued, cmds_taken, mismatches, stuck_cycles;
  int send_hold, sink_hold;
  bit send_calm, sink_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append a packet at the tail; refuse when the ring is full
  function automatic bit ring_push(logic [31:0] msg, logic [7:0] node, logic [3:0] tries,
                                   logic [31:0] when);
    if (count_q >= QDEPTH) return 1'b0;
    ring[tail_q] = '{message: msg, node: node, retries: tries, retry_time: when};
    tail_q = (tail_q + 1) % QDEPTH;
    count_q++;
    return 1'b1;
  endfunction

  // Apply one command to the queue copy and return the result it causes
  function automatic result_t radio_step(item_t it);
    result_t r;
    logic [31:0] msg;
    logic [31:0] due;
    logic [3:0] tries;
    bit ok;
    r = '0;
    r.kind = KIND_IDLE;
    case (it.cmd)
      CMD_ENQ: begin
        msg = {MSG_TAG, it.dev_cmd, it.dev_id, it.payload};
        ok = radio_cfg.radio_en;
        if (!link_up && count_q != 0) ok = 1'b0;
        if (count_q > radio_cfg.queue_limit) ok = 1'b0;
        if (ok) ok = ring_push(msg, it.dest_node, '0, '0);
        r.kind = KIND_ENQ;
        r.accepted = ok;
        r.message = msg;
        r.out_node = it.dest_node;
      end
      CMD_TICK: begin
        now_ms = now_ms + 32'd1;
        if (radio_cfg.radio_en && !flying && next_send <= now_ms && count_q != 0) begin
          if (ring[head_q].retries == 0 || ring[head_q].retry_time <= now_ms) begin
            flight.message = ring[head_q].message;
            flight.node = ring[head_q].node;
            flight.retries = ring[head_q].retries;
            head_q = (head_q + 1) % QDEPTH;
            count_q--;
            flying = 1'b1;
            r.kind = KIND_TX;
            r.message = flight.message;
            r.out_node = flight.node;
            r.retry_count = flight.retries;
          end
        end
      end
      CMD_OUTCOME: begin
        if (flying) begin
          flying = 1'b0;
          r.kind = KIND_REPORT;
          r.message = flight.message;
          r.out_node = flight.node;
          if (it.write_ok) begin
            r.report = REP_SENT;
            r.retry_count = flight.retries;
            if (!radio_cfg.is_server) link_up = 1'b1;
          end else begin
            tries = (flight.retries == RETRY_SAT) ? RETRY_SAT : flight.retries + 4'd1;
            r.retry_count = tries;
            due = now_ms + {16'd0, radio_cfg.retry_delay};
            ok = 1'b0;
            if (flight.retries < radio_cfg.max_retries)
              ok = ring_push(flight.message, flight.node, tries, due);
            if (ok) begin
              r.report = REP_RETRY;
            end else begin
              r.report = REP_DROP;
              if (!radio_cfg.is_server) link_up = 1'b0;
            end
          end
          next_send = now_ms + {16'd0, radio_cfg.send_gap};
        end
      end
      default: ;
    endcase
    r.link_up = link_up;
    return r;
  endfunction

  // Mostly short idle runs, some long ones; none while calm
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t rand_cmd(logic [1:0] code);
    item_t it;
    it.cmd = code;
    it.dev_cmd = 4'($urandom);
    it.dev_id = 8'($urandom);
    it.payload = 16'($urandom);
    it.dest_node = 8'($urandom);
    it.write_ok = 1'($urandom);
    return it;
  endfunction

  function automatic item_t outcome_cmd(bit ok);
    item_t it;
    it = rand_cmd(CMD_OUTCOME);
    it.write_ok = ok;
    return it;
  endfunction

  function automatic void push_cmd(item_t it);
    cmd_backlog.push_back(it);
    cmds_issued++;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Write every register while the block is idle
  task automatic set_config(cfg_t c);
    write_reg(CFG_RADIO_EN, CFG_DATA_W'(c.radio_en));
    write_reg(CFG_IS_SERVER, CFG_DATA_W'(c.is_server));
    write_reg(CFG_QUEUE_LIMIT, CFG_DATA_W'(c.queue_limit));
    write_reg(CFG_MAX_RETRIES, CFG_DATA_W'(c.max_retries));
    write_reg(CFG_RETRY_DELAY, c.retry_delay);
    write_reg(CFG_SEND_GAP, c.send_gap);
    @(posedge clk);
    cfg_we <= 1'b0;
    radio_cfg = c;
    @(negedge clk);
  endtask

  // Hold until every command is taken and every result has come back
  task automatic drain();
    do @(negedge clk); while (cmds_taken != cmds_issued || result_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic built mostly from well-formed send sequences
  task automatic gen_traffic(int n_items);
    int start, pick, reps, waits, k;
    waits = (radio_cfg.send_gap > radio_cfg.retry_delay) ? int'(radio_cfg.send_gap)
                                                         : int'(radio_cfg.retry_delay);
    waits = (waits > 10) ? 12 : waits + 2;
    start = cmds_issued;
    while (cmds_issued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        reps = $urandom_range(1, 5);
        repeat (reps) push_cmd(rand_cmd(CMD_ENQ));
      end else if (pick < 75) begin
        reps = $urandom_range(1, waits);
        repeat (reps) push_cmd(rand_cmd(CMD_TICK));
        push_cmd(outcome_cmd($urandom_range(0, 9) < 7));
      end else if (pick < 87) begin
        // chain of failed attempts, at times long enough to saturate the retry count
        reps = $urandom_range(1, 17);
        for (k = 0; k < reps; k++) begin
          repeat ($urandom_range(1, waits)) push_cmd(rand_cmd(CMD_TICK));
          push_cmd(outcome_cmd(1'b0));
        end
      end else begin
        reps = $urandom_range(1, 4);
        repeat (reps) push_cmd(rand_cmd(2'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic run_phase(cfg_t c, int n_items);
    set_config(c);
    gen_traffic(n_items);
    drain();
  endtask

  // Drive the next command once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_hold = 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      if (send_hold > 0) begin
        in_chan.valid <= 1'b0;
        send_hold--;
      end else if (cmd_backlog.size() != 0) begin
        in_chan.data <= cmd_backlog.pop_front();
        in_chan.valid <= 1'b1;
        send_hold = idle_len(send_calm);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      if (sink_hold > 0) begin
        out_chan.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_chan.ready <= 1'b1;
        sink_hold = idle_len(sink_calm);
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want_v, got_v);
      mismatches++;
    end
  endtask

  // Predict on each taken command, then check each delivered result
  always @(posedge clk) begin : monitor
    result_t want, got;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        result_queue.push_back(radio_step(in_chan.data));
        cmds_taken++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("message", want.message, got.message);
          check_field("out_node", 32'(want.out_node), 32'(got.out_node));
          check_field("report", 32'(want.report), 32'(got.report));
          check_field("retry_count", 32'(want.retry_count), 32'(got.retry_count));
          check_field("link_up", 32'(want.link_up), 32'(got.link_up));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("tb_tx_retry_queue_unit failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    item_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    head_q = 0;
    tail_q = 0;
    count_q = 0;
    flying = 1'b0;
    flight = '0;
    now_ms = '0;
    next_send = '0;
    link_up = 1'b0;
    radio_cfg = '{radio_en: 1'b0, is_server: 1'b0, queue_limit: RST_QUEUE_LIMIT,
                  max_retries: RST_MAX_RETRIES, retry_delay: RST_RETRY_DELAY,
                  send_gap: RST_SEND_GAP};
    cmds_issued = 0;
    cmds_taken = 0;
    mismatches = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Radio off after reset: nothing queued, nothing sent
    push_cmd('{cmd: CMD_ENQ, default: '0});
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(outcome_cmd(1'b1));
    push_cmd(rand_cmd(CMD_UNUSED));
    drain();

    // Directed walk: refusal on a down link, retry, drop, success
    set_config('{radio_en: 1'b1, is_server: 1'b0, queue_limit: 4'd13, max_retries: 4'd1,
                 retry_delay: 16'd0, send_gap: 16'd0});
    push_cmd('{cmd: CMD_ENQ, default: '0});
    push_cmd('{cmd: CMD_ENQ, dev_cmd: 4'hF, dev_id: 8'hFF, payload: 16'hFFFF,
               dest_node: 8'hFF, write_ok: 1'b1});
    push_cmd(outcome_cmd(1'b1));
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(outcome_cmd(1'b0));
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(outcome_cmd(1'b0));
    push_cmd('{cmd: CMD_ENQ, dev_cmd: 4'hF, dev_id: 8'hFF, payload: 16'hFFFF,
               dest_node: 8'hFF, write_ok: 1'b0});
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(outcome_cmd(1'b1));
    repeat (3) push_cmd(rand_cmd(CMD_ENQ));
    it = rand_cmd(CMD_UNUSED);
    push_cmd(it);
    push_cmd(rand_cmd(CMD_TICK));
    push_cmd(outcome_cmd(1'b1));
    drain();

    // Random traffic over a range of settings
    run_phase('{radio_en: 1'b1, is_server: 1'b0, queue_limit: 4'd13, max_retries: 4'd15,
                retry_delay: 16'd0, send_gap: 16'd0}, 400);
    run_phase('{radio_en: 1'b1, is_server: 1'b1, queue_limit: 4'd13, max_retries: 4'd2,
                retry_delay: 16'd3, send_gap: 16'd1}, 250);
    run_phase('{radio_en: 1'b1, is_server: 1'b1, queue_limit: 4'd0, max_retries: 4'd0,
                retry_delay: 16'd1, send_gap: 16'd2}, 200);
    repeat (3) begin
      run_phase('{radio_en: 1'b1, is_server: 1'($urandom_range(0, 1)),
                  queue_limit: 4'($urandom_range(0, 13)),
                  max_retries: 4'($urandom_range(0, 15)),
                  retry_delay: 16'($urandom_range(0, 9)),
                  send_gap: 16'($urandom_range(0, 4))}, 250);
    end
    run_phase('{radio_en: 1'b0, is_server: 1'b0, queue_limit: 4'd10, max_retries: 4'd10,
                retry_delay: 16'd5, send_gap: 16'd3}, 60);
    run_phase('{radio_en: 1'b1, is_server: 1'b0, queue_limit: 4'd2, max_retries: 4'd15,
                retry_delay: 16'd7, send_gap: 16'd0}, 100);
    // Longest delays last: the send gap then blocks transmits for good
    run_phase('{radio_en: 1'b1, is_server: 1'b1, queue_limit: 4'd13, max_retries: 4'd15,
                retry_delay: 16'hFFFF, send_gap: 16'hFFFF}, 50);

    repeat (10) @(negedge clk);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("tb_tx_retry_queue_unit passed");
    end else begin
      $display("tb_tx_retry_queue_unit failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/trq_pkg.sv
rtl/trq_stream_if.sv
rtl/trq_queue_mem.sv
rtl/trq_ctrl.sv
rtl/tx_retry_queue_unit.sv
tb/tb_tx_retry_queue_unit.sv
